// ===== rtl/assert_macros.svh =====
// Assertion macros for the compressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/bdcc_pkg.sv =====
// Types and constants of the bitmask dictionary code compressor.
package bdcc_pkg;

    localparam int WORD_BITS     = 32;
    localparam int DICT_SLOTS    = 8;
    localparam int DICT_IDX_BITS = 3;
    localparam int POS_BITS      = 5;
    localparam int MAX_RUN       = 4;
    localparam int RUN_BITS      = 3;
    localparam int CODE_W        = 40;
    localparam int ENTRY_CODE_W  = 35;
    localparam int LEN_W         = 6;

    // format prefixes
    localparam logic [2:0] OP_RUN      = 3'b000;
    localparam logic [2:0] OP_MASK     = 3'b001;
    localparam logic [2:0] OP_ONE      = 3'b010;
    localparam logic [2:0] OP_TWO_ADJ  = 3'b011;
    localparam logic [2:0] OP_TWO_FAR  = 3'b100;
    localparam logic [2:0] OP_DIRECT   = 3'b101;
    localparam logic [2:0] OP_RAW      = 3'b110;

    // code lengths
    localparam logic [LEN_W-1:0] LEN_RUN     = 6'd5;
    localparam logic [LEN_W-1:0] LEN_DIRECT  = 6'd6;
    localparam logic [LEN_W-1:0] LEN_ONE     = 6'd11;
    localparam logic [LEN_W-1:0] LEN_TWO_ADJ = 6'd11;
    localparam logic [LEN_W-1:0] LEN_MASK    = 6'd15;
    localparam logic [LEN_W-1:0] LEN_TWO_FAR = 6'd16;
    localparam logic [LEN_W-1:0] LEN_RAW     = 6'd35;
    localparam logic [LEN_W-1:0] LEN_NONE    = 6'd40;

    typedef struct packed {
        logic [WORD_BITS-1:0] data_word;
        logic                 end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } out_item_t;

    typedef struct packed {
        logic [ENTRY_CODE_W-1:0] code;
        logic [LEN_W-1:0]        len;
    } coder_res_t;

endpackage

// ===== rtl/bitmask_dictionary_code_compressor.sv =====
// Top level of the bitmask dictionary code compressor.
//
//  port group  dir   handshake          carries
//  s_          in    s_valid / s_ready  in_item_t  (data_word, end_of_stream)
//  m_          out   m_valid / m_ready  out_item_t (code_bits, code_length)
//  cfg_        in    cfg_we             cfg_index, cfg_data (dictionary words)
//
// One item per cycle sustained while m_ready is high; an item passes the input stage
// register, then the result register, on its way to m_, with the parallel coders
// (one per dictionary entry) and the length select between them.
// A repeat of the previous word is absorbed into the run count and yields no item unless it ends the stream.
// Reset clears the dictionary, the previous word and the run state.
// s_ready drops only while both stages hold items and m_ready is low.
`include "assert_macros.svh"
module bitmask_dictionary_code_compressor
    import bdcc_pkg::*;
#(
    parameter int DICT_ENTRIES = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [DICT_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]     cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_item
);

    logic [WORD_BITS-1:0] dict_reg [DICT_ENTRIES];

    logic [WORD_BITS-1:0] prev_word_reg, prev_word_next;
    logic                 prev_valid_reg, prev_valid_next;
    logic [RUN_BITS-1:0]  run_count_reg, run_count_next;

    logic                 st_valid_reg;
    logic [WORD_BITS-1:0] st_word_reg;
    logic                 st_has_word_reg, st_has_word_next;
    logic                 st_has_run_reg, st_has_run_next;
    logic [1:0]           st_run_code_reg, st_run_code_next;
    logic                 emit_next;

    logic                 m_valid_reg;
    out_item_t            m_item_reg, m_item_next;

    logic                 s_fire;
    logic                 out_ready;
    logic                 is_repeat;

    coder_res_t           coder_res [DICT_ENTRIES];
    logic [ENTRY_CODE_W-1:0] best_code;
    logic [LEN_W-1:0]     best_len;
    logic [4:0]           run_field;

    assign out_ready = !m_valid_reg || m_ready;
    assign s_ready   = !st_valid_reg || out_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // dictionary
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            if (!aresetn) begin
                dict_reg[i] <= '0;
            end else if (cfg_we && cfg_index == DICT_IDX_BITS'(i)) begin
                dict_reg[i] <= cfg_data;
            end
        end
    end

    // run tracking at accept
    always_comb begin
        is_repeat        = prev_valid_reg && (s_item.data_word == prev_word_reg)
                           && (run_count_reg < RUN_BITS'(MAX_RUN));
        prev_word_next   = prev_word_reg;
        prev_valid_next  = prev_valid_reg;
        run_count_next   = run_count_reg;
        st_has_word_next = 1'b0;
        st_has_run_next  = 1'b0;
        st_run_code_next = 2'(run_count_reg - RUN_BITS'(1));
        emit_next        = 1'b0;
        if (s_fire) begin
            if (is_repeat) begin
                st_has_run_next  = 1'b1;
                st_run_code_next = run_count_reg[1:0];
                emit_next        = s_item.end_of_stream;
                run_count_next   = s_item.end_of_stream ? '0 : run_count_reg + RUN_BITS'(1);
                prev_valid_next  = !s_item.end_of_stream;
            end else begin
                st_has_word_next = 1'b1;
                st_has_run_next  = prev_valid_reg && (run_count_reg != '0);
                emit_next        = 1'b1;
                prev_word_next   = s_item.data_word;
                prev_valid_next  = !s_item.end_of_stream;
                run_count_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_word_reg  <= '0;
            prev_valid_reg <= 1'b0;
            run_count_reg  <= '0;
            st_valid_reg   <= 1'b0;
        end else begin
            prev_word_reg  <= prev_word_next;
            prev_valid_reg <= prev_valid_next;
            run_count_reg  <= run_count_next;
            if (s_ready) begin
                st_valid_reg <= emit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st_word_reg     <= s_item.data_word;
            st_has_word_reg <= st_has_word_next;
            st_has_run_reg  <= st_has_run_next;
            st_run_code_reg <= st_run_code_next;
        end
    end

    // per-entry coders
    for (genvar g = 0; g < DICT_ENTRIES; g++) begin : g_coder
        bdcc_coder u_coder (
            .word      (st_word_reg),
            .dict_word (dict_reg[g]),
            .idx       (DICT_IDX_BITS'(g)),
            .res       (coder_res[g])
        );
    end

    // shortest code, lowest index on a tie
    always_comb begin
        best_len  = LEN_NONE;
        best_code = '0;
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            if (coder_res[i].len < best_len) begin
                best_len  = coder_res[i].len;
                best_code = coder_res[i].code;
            end
        end
    end

    assign run_field = {OP_RUN, st_run_code_reg};

    always_comb begin
        if (st_has_word_reg) begin
            if (st_has_run_reg) begin
                m_item_next.code_bits   = (CODE_W'(run_field) << best_len)
                                          | CODE_W'(best_code);
                m_item_next.code_length = best_len + LEN_RUN;
            end else begin
                m_item_next.code_bits   = CODE_W'(best_code);
                m_item_next.code_length = best_len;
            end
        end else begin
            m_item_next.code_bits   = CODE_W'(run_field);
            m_item_next.code_length = LEN_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && st_valid_reg) begin
            m_item_reg <= m_item_next;
        end
    end

    `ASSERT_RST(a_len_range, aclk, aresetn, m_valid |-> (m_item.code_length >= LEN_RUN) && (m_item.code_length <= LEN_NONE))
    `ASSERT_RST(a_run_cap, aclk, aresetn, run_count_reg <= RUN_BITS'(MAX_RUN))
    `ASSERT_RST(a_no_run_without_word, aclk, aresetn, !prev_valid_reg |-> run_count_reg == '0)
    `ASSERT_RST(a_stage_nonempty, aclk, aresetn, (st_valid_reg && !st_has_word_reg) |-> st_has_run_reg)
    `ASSERT_RST(a_eos_ends_stream, aclk, aresetn, (s_fire && s_item.end_of_stream) |=> !prev_valid_reg)
    `ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid && !st_valid_reg)

endmodule

// ===== rtl/bdcc_coder.sv =====
// Codes one word against one dictionary entry and reports the code length.
module bdcc_coder
    import bdcc_pkg::*;
(
    input  logic [WORD_BITS-1:0]     word,
    input  logic [WORD_BITS-1:0]     dict_word,
    input  logic [DICT_IDX_BITS-1:0] idx,
    output coder_res_t               res
);

    function automatic logic [POS_BITS-1:0] first_pos(input logic [WORD_BITS-1:0] x);
        logic [POS_BITS-1:0] p;
        p = POS_BITS'(WORD_BITS - 1);
        for (int i = 0; i < WORD_BITS; i++) begin
            if (x[i]) begin
                p = POS_BITS'(WORD_BITS - 1 - i);
            end
        end
        return p;
    endfunction

    function automatic logic [POS_BITS-1:0] last_pos(input logic [WORD_BITS-1:0] x);
        logic [POS_BITS-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (x[i]) begin
                p = POS_BITS'(WORD_BITS - 1 - i);
            end
        end
        return p;
    endfunction

    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] diff_sh;
    logic [LEN_W-1:0]     n_ones;
    logic [POS_BITS-1:0]  f_pos;
    logic [POS_BITS-1:0]  l_pos;
    logic [POS_BITS-1:0]  span;
    logic [3:0]           mask;

    assign diff    = word ^ dict_word;
    assign n_ones  = LEN_W'($countones(diff));
    assign f_pos   = first_pos(diff);
    assign l_pos   = last_pos(diff);
    assign span    = l_pos - f_pos;
    assign diff_sh = diff << f_pos;
    assign mask    = diff_sh[WORD_BITS-1 -: 4];

    always_comb begin
        priority if (n_ones == '0) begin
            res.code = ENTRY_CODE_W'({OP_DIRECT, idx});
            res.len  = LEN_DIRECT;
        end else if (n_ones == LEN_W'(1)) begin
            res.code = ENTRY_CODE_W'({OP_ONE, f_pos, idx});
            res.len  = LEN_ONE;
        end else if (n_ones == LEN_W'(2) && span == POS_BITS'(1)) begin
            res.code = ENTRY_CODE_W'({OP_TWO_ADJ, f_pos, idx});
            res.len  = LEN_TWO_ADJ;
        end else if (n_ones <= LEN_W'(4) && span <= POS_BITS'(3)) begin
            res.code = ENTRY_CODE_W'({OP_MASK, f_pos, mask, idx});
            res.len  = LEN_MASK;
        end else if (n_ones == LEN_W'(2)) begin
            res.code = ENTRY_CODE_W'({OP_TWO_FAR, f_pos, l_pos, idx});
            res.len  = LEN_TWO_FAR;
        end else begin
            res.code = {OP_RAW, word};
            res.len  = LEN_RAW;
        end
    end

endmodule
